// ===== sv/i2p_pkg.sv =====
// shared constants, types and character-class functions for the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	// precedence as 0..3, where 0 stands for every non-operator
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_PLUS, CH_MINUS: p = 2'd1;
			CH_STAR, CH_SLASH: p = 2'd2;
			CH_CARET:          p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

// ===== sv/i2p_cell.sv =====
// one entry of the shifting operator stack
`timescale 1ns / 1ps

module i2p_cell import i2p_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic [7:0] upper_data,
	input  logic       upper_valid,
	input  logic [7:0] lower_data,
	input  logic       lower_valid,
	output logic [7:0] data,
	output logic       valid
);

	logic [7:0] data_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			valid_q <= upper_valid;
		end else if (ctl.pop) begin
			valid_q <= lower_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= upper_data;
		end else if (ctl.pop) begin
			data_q <= lower_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ===== sv/infix_to_postfix_converter_core.sv =====
// top level of the infix to postfix converter: sequencer, cell chain and output register
`timescale 1ns / 1ps

// Converts an infix expression, one ASCII character per input transaction (tlast on the
// final character), into postfix, one character per output transaction; the expression
// closes with a transaction carrying 0 and tlast, and tuser carries the sticky overflow
// flag. The operator stack is a chain of STACK_DEPTH cells that shift together on every
// push or pop, with the top in the first cell. Each character is accepted, then decided
// against the top cell, one popped operator per step; after the final character each
// remaining stack entry is popped and then the terminator is sent. A stalled output
// holds the sequencer. No clearing pass is needed after reset.
module infix_to_postfix_converter_core import i2p_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,   // end_of_expression
	output logic [0:0] m_tuser    // [0] overflow
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_OP    = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d, done_state;

	logic [7:0] char_q;
	logic       last_q;
	logic       overflow_q;
	logic       set_ovf;

	logic [7:0] cell_data [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] valid_vec;
	cell_ctl_t  ctl;

	logic [7:0] top;
	logic       top_valid, top_lp, full;

	logic       m_tvalid_q, m_tlast_q;
	logic [7:0] m_tdata_q;
	logic [0:0] m_tuser_q;
	logic       out_free, emit, emit_end;
	logic [7:0] emit_char;

	// cell chain
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [7:0] up_d, lo_d;
		logic       up_v, lo_v;
		if (i == 0) begin : g_top
			assign up_d = char_q;
			assign up_v = 1'b1;
		end else begin : g_mid
			assign up_d = cell_data[i-1];
			assign up_v = valid_vec[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign lo_d = CH_NUL;
			assign lo_v = 1'b0;
		end else begin : g_lo
			assign lo_d = cell_data[i+1];
			assign lo_v = valid_vec[i+1];
		end
		i2p_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.upper_data  (up_d),
			.upper_valid (up_v),
			.lower_data  (lo_d),
			.lower_valid (lo_v),
			.data        (cell_data[i]),
			.valid       (valid_vec[i])
		);
	end

	assign top        = cell_data[0];
	assign top_valid  = valid_vec[0];
	assign top_lp     = (top == CH_LPAREN);
	assign full       = valid_vec[STACK_DEPTH-1];
	assign out_free   = !m_tvalid_q || m_tready;
	assign done_state = last_q ? S_FLUSH : S_IDLE;
	assign s_tready   = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		set_ovf   = 1'b0;
		emit      = 1'b0;
		emit_char = top;
		emit_end  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_OP;
				end
			end
			S_OP: begin
				if (is_operand(char_q)) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_char = char_q;
						state_d   = done_state;
					end
				end else if (char_q == CH_LPAREN) begin
					ctl.push = !full;
					set_ovf  = full;
					state_d  = done_state;
				end else if (char_q == CH_RPAREN) begin
					if (top_valid && !top_lp) begin
						if (out_free) begin
							emit    = 1'b1;
							ctl.pop = 1'b1;
						end
					end else begin
						ctl.pop = top_valid;
						state_d = done_state;
					end
				end else if (top_valid && !top_lp && prec_of(char_q) <= prec_of(top)) begin
					if (out_free) begin
						emit    = 1'b1;
						ctl.pop = 1'b1;
					end
				end else begin
					ctl.push = !full;
					set_ovf  = full;
					state_d  = done_state;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					if (top_valid) begin
						ctl.pop = 1'b1;
					end else begin
						emit_char = CH_NUL;
						emit_end  = 1'b1;
						state_d   = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			overflow_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_ovf) begin
				overflow_q <= 1'b1;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (emit) begin
			m_tdata_q    <= emit_char;
			m_tlast_q    <= emit_end;
			m_tuser_q[0] <= overflow_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("stack cells not filled from the top");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("push and pop in the same cycle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> top_valid)
		else $error("pop from an empty stack");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result written over a pending transaction");
`endif

endmodule
